// ----- sv/tlli_pkg.sv -----
// Shared types, codes and helpers for the table lookup and linear interpolation unit.
package tlli_pkg;

  localparam int DEFAULT_TABLE_DEPTH = 64;
  localparam int COUNT_W = 7;
  localparam int INDEX_W = 6;
  localparam int DATA_W = 32;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic [1:0] STATUS_EXACT = 2'd0;
  localparam logic [1:0] STATUS_INTERP = 2'd1;
  localparam logic [1:0] STATUS_NONE = 2'd2;

  localparam logic [1:0] PROP_VOLUME = 2'd0;
  localparam logic [1:0] PROP_ENERGY = 2'd1;
  localparam logic [1:0] PROP_ENTHALPY = 2'd2;
  localparam logic [1:0] PROP_ENTROPY = 2'd3;

  localparam logic signed [DATA_W:0] MATCH_TOL = 33'sd655;

  typedef struct packed {
    logic command;
    logic [INDEX_W-1:0] entry_index;
    logic signed [DATA_W-1:0] temperature;
    logic signed [DATA_W-1:0] pressure;
    logic signed [DATA_W-1:0] volume;
    logic signed [DATA_W-1:0] internal_energy;
    logic signed [DATA_W-1:0] enthalpy;
    logic signed [DATA_W-1:0] entropy;
    logic [1:0] property_select;
  } req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic [1:0] status;
  } rsp_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] entropy;
    logic signed [DATA_W-1:0] enthalpy;
    logic signed [DATA_W-1:0] energy;
    logic signed [DATA_W-1:0] volume;
    logic signed [DATA_W-1:0] pressure;
    logic signed [DATA_W-1:0] temperature;
  } row_t;

  function automatic logic signed [DATA_W-1:0] prop_pick(row_t r, logic [1:0] sel);
    logic signed [DATA_W-1:0] v;
    unique case (sel)
      PROP_VOLUME:   v = r.volume;
      PROP_ENERGY:   v = r.energy;
      PROP_ENTHALPY: v = r.enthalpy;
      PROP_ENTROPY:  v = r.entropy;
      default:       v = r.volume;
    endcase
    return v;
  endfunction

endpackage

// ----- sv/table_lookup_linear_interp_unit.sv -----
// Top level of the table lookup and linear interpolation unit.
//
//  channel  | handshake            | payload             | notes
//  ---------+----------------------+---------------------+------------------------------
//  command  | start, busy          | req  (req_t)        | word taken when start & !busy
//  result   | done (1-cycle pulse) | rsp  (rsp_t)        | queries only, cannot be held off
//  config   | cfg_wr               | cfg_data (7 bits)   | entry_count, write when idle
//
// A load writes its row while idle and leaves busy low. A query runs the exact-match scan,
// then, if no row matched, the bracket scan (n = rows in use, one RAM read a cycle); an
// interpolation adds a setup state, a start of the shared adder, 32 multiply and 33 divide
// steps and the taking of the quotient. Reset clears the sequencer and entry_count; table
// rows stay undefined until loaded. The receiver cannot stall; each result is flagged by
// done for one cycle.
module table_lookup_linear_interp_unit #(
  parameter int TABLE_DEPTH = tlli_pkg::DEFAULT_TABLE_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  tlli_pkg::req_t                 req,
  output logic                           done,
  output tlli_pkg::rsp_t                 rsp,
  input  logic                           cfg_wr,
  input  logic [tlli_pkg::COUNT_W-1:0]   cfg_data
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CntW = $clog2(TABLE_DEPTH + 1);
  localparam int RowW = $bits(tlli_pkg::row_t);

  typedef enum logic [2:0] {S_IDLE, S_EXACT, S_BRACKET, S_PREP, S_WAIT} state_t;

  state_t                      state;
  logic [tlli_pkg::COUNT_W-1:0] entry_count;
  logic [CntW-1:0]             row;
  logic [CntW-1:0]             n;
  logic                        vld;
  logic                        have_prev;
  logic signed [31:0]          q_temp;
  logic signed [31:0]          q_pres;
  logic [1:0]                  q_sel;
  logic signed [31:0]          prev_t;
  logic signed [31:0]          prev_y;
  logic signed [31:0]          x1;
  logic signed [31:0]          y1;
  logic signed [31:0]          x2;
  logic signed [31:0]          y2;
  logic [31:0]                 dx;
  logic [32:0]                 dy_mag;
  logic [31:0]                 den;
  logic                        dy_neg;
  logic                        md_start;
  logic                        md_done;
  logic [32:0]                 quot;

  logic                        issue;
  logic                        load_we;
  logic [RowW-1:0]             wdata;
  logic [RowW-1:0]             rdata;
  tlli_pkg::row_t              wr_row;
  tlli_pkg::row_t              rd_row;
  logic signed [31:0]          rd_prop;
  logic signed [32:0]          d_temp;
  logic signed [32:0]          d_pres;
  logic                        hit;
  logic                        bracket;
  logic signed [32:0]          dy_full;
  logic signed [34:0]          sum;
  logic signed [31:0]          sat;

  assign busy = (state != S_IDLE);

  always_comb begin
    if (32'(entry_count) > 32'(TABLE_DEPTH)) begin
      n = CntW'(TABLE_DEPTH);
    end else begin
      n = CntW'(entry_count);
    end
    issue = ((state == S_EXACT) || (state == S_BRACKET)) && (row < n);
    load_we = start && !busy && (req.command == tlli_pkg::CMD_LOAD) &&
              (32'(req.entry_index) < 32'(TABLE_DEPTH));
    wr_row.temperature = req.temperature;
    wr_row.pressure = req.pressure;
    wr_row.volume = req.volume;
    wr_row.energy = req.internal_energy;
    wr_row.enthalpy = req.enthalpy;
    wr_row.entropy = req.entropy;
    wdata = wr_row;
    rd_row = tlli_pkg::row_t'(rdata);
    rd_prop = tlli_pkg::prop_pick(rd_row, q_sel);
    d_temp = {rd_row.temperature[31], rd_row.temperature} - {q_temp[31], q_temp};
    d_pres = {rd_row.pressure[31], rd_row.pressure} - {q_pres[31], q_pres};
    hit = (d_temp <= tlli_pkg::MATCH_TOL) && (d_temp >= -tlli_pkg::MATCH_TOL) &&
          (d_pres <= tlli_pkg::MATCH_TOL) && (d_pres >= -tlli_pkg::MATCH_TOL);
    bracket = have_prev && (prev_t <= q_temp) && (q_temp <= rd_row.temperature);
    dy_full = {y2[31], y2} - {y1[31], y1};
    sum = {{3{y1[31]}}, y1} + (dy_neg ? -$signed({2'b00, quot}) : $signed({2'b00, quot}));
    if ((sum[34:31] == 4'b0000) || (sum[34:31] == 4'b1111)) begin
      sat = sum[31:0];
    end else if (sum[34]) begin
      sat = 32'sh8000_0000;
    end else begin
      sat = 32'sh7fff_ffff;
    end
  end

  tlli_ram #(
    .WIDTH(RowW),
    .DEPTH(TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (load_we),
    .waddr (AW'(req.entry_index)),
    .wdata (wdata),
    .re    (issue),
    .raddr (row[AW-1:0]),
    .rdata (rdata)
  );

  tlli_muldiv u_muldiv (
    .clk    (clk),
    .rst    (rst),
    .start  (md_start),
    .dx     (dx),
    .dy_mag (dy_mag),
    .den    (den),
    .done   (md_done),
    .quot   (quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (cfg_wr) begin
      entry_count <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done <= 1'b0;
      md_start <= 1'b0;
      vld <= 1'b0;
      have_prev <= 1'b0;
      row <= '0;
    end else begin
      done <= 1'b0;
      md_start <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start && (req.command == tlli_pkg::CMD_QUERY)) begin
            q_temp <= req.temperature;
            q_pres <= req.pressure;
            q_sel <= req.property_select;
            row <= '0;
            vld <= 1'b0;
            state <= S_EXACT;
          end
        end
        S_EXACT: begin
          vld <= issue;
          if (issue) begin
            row <= row + CntW'(1);
          end
          if (vld && hit) begin
            rsp.value <= rd_prop;
            rsp.status <= tlli_pkg::STATUS_EXACT;
            done <= 1'b1;
            vld <= 1'b0;
            state <= S_IDLE;
          end else if (!vld && !issue) begin
            row <= '0;
            have_prev <= 1'b0;
            state <= S_BRACKET;
          end
        end
        S_BRACKET: begin
          vld <= issue;
          if (issue) begin
            row <= row + CntW'(1);
          end
          if (vld) begin
            if (bracket) begin
              x1 <= prev_t;
              y1 <= prev_y;
              x2 <= rd_row.temperature;
              y2 <= rd_prop;
              vld <= 1'b0;
              state <= S_PREP;
            end else begin
              prev_t <= rd_row.temperature;
              prev_y <= rd_prop;
              have_prev <= 1'b1;
            end
          end else if (!issue) begin
            rsp.value <= '0;
            rsp.status <= tlli_pkg::STATUS_NONE;
            done <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_PREP: begin
          if (x2 == x1) begin
            rsp.value <= y1;
            rsp.status <= tlli_pkg::STATUS_INTERP;
            done <= 1'b1;
            state <= S_IDLE;
          end else begin
            dx <= 32'(q_temp - x1);
            den <= 32'(x2 - x1);
            dy_neg <= dy_full[32];
            dy_mag <= dy_full[32] ? 33'(-dy_full) : 33'(dy_full);
            md_start <= 1'b1;
            state <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (md_done) begin
            rsp.value <= sat;
            rsp.status <= tlli_pkg::STATUS_INTERP;
            done <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- sv/tlli_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module tlli_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/tlli_muldiv.sv -----
// Serial multiply then restoring divide on one shared adder: quot = dx * dy_mag / den.
module tlli_muldiv (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dx,
  input  logic [32:0] dy_mag,
  input  logic [31:0] den,
  output logic        done,
  output logic [32:0] quot
);

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV} state_t;

  state_t      state;
  logic [5:0]  count;
  logic [33:0] hi;
  logic [31:0] lo;
  logic [32:0] mcand;
  logic [31:0] den_r;
  logic [31:0] rem;
  logic [32:0] dq;

  logic [33:0] add_a;
  logic [33:0] add_b;
  logic        add_sub;
  logic [33:0] add_y;
  logic [32:0] rem_sh;
  logic [33:0] hi_sum;
  logic [65:0] mul_sh;
  logic        ge;

  always_comb begin
    rem_sh = {rem, dq[32]};
    if (state == S_DIV) begin
      add_a = {1'b0, rem_sh};
      add_b = {2'b00, den_r};
      add_sub = 1'b1;
    end else begin
      add_a = hi;
      add_b = {1'b0, mcand};
      add_sub = 1'b0;
    end
    add_y = add_a + (add_sub ? ~add_b : add_b) + 34'(add_sub);
    hi_sum = lo[0] ? add_y : hi;
    mul_sh = {1'b0, hi_sum, lo[31:1]};
    ge = !add_y[33];
  end

  assign quot = dq;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            hi <= '0;
            lo <= dx;
            mcand <= dy_mag;
            den_r <= den;
            count <= 6'd32;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          count <= count - 6'd1;
          if (count == 6'd1) begin
            rem <= {1'b0, mul_sh[63:33]};
            dq <= mul_sh[32:0];
            count <= 6'd33;
            state <= S_DIV;
          end else begin
            hi <= mul_sh[65:32];
            lo <= mul_sh[31:0];
          end
        end
        S_DIV: begin
          count <= count - 6'd1;
          rem <= ge ? add_y[31:0] : rem_sh[31:0];
          dq <= {dq[31:0], ge};
          if (count == 6'd1) begin
            done <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- tb/tb.sv -----
// Testbench for the table lookup and interpolation unit, checked by an in-bench predictor.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef longint unsigned u64_t;

  localparam int ROWS = tlli_pkg::DEFAULT_TABLE_DEPTH;
  localparam int SETTLE_CYCLES = 2 * ROWS + 100;
  localparam int I32_MIN = 32'sh8000_0000;
  localparam int I32_MAX = 32'sh7fff_ffff;
  localparam int WORD_TARGET = 530;
  localparam int COUNT_PLAN[9] = '{2, 64, 127, 3, 65, 0, 1, 100, 5};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic cfg_wr = 1'b0;
  logic [tlli_pkg::COUNT_W-1:0] cfg_data = '0;
  tlli_pkg::req_t req = '0;
  logic busy;
  logic done;
  tlli_pkg::rsp_t rsp;

  tlli_pkg::req_t word_queue[$];
  tlli_pkg::rsp_t expected_results[$];
  tlli_pkg::rsp_t want;
  tlli_pkg::row_t table_rows[ROWS];
  int entry_count_model = 0;
  int mismatch_count = 0;
  int sender_idle_pct = 7;
  int words_queued = 0;
  int gen_temp[ROWS];
  int gen_pres[ROWS];

  table_lookup_linear_interp_unit i_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .req(req),
    .done(done),
    .rsp(rsp),
    .cfg_wr(cfg_wr),
    .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  function automatic longint wide(logic signed [tlli_pkg::DATA_W-1:0] x);
    return x;
  endfunction

  function automatic longint magnitude(longint x);
    return (x < 0) ? -x : x;
  endfunction

  function automatic longint row_prop(int i, logic [1:0] sel);
    case (sel)
      tlli_pkg::PROP_VOLUME: return wide(table_rows[i].volume);
      tlli_pkg::PROP_ENERGY: return wide(table_rows[i].energy);
      tlli_pkg::PROP_ENTHALPY: return wide(table_rows[i].enthalpy);
      default: return wide(table_rows[i].entropy);
    endcase
  endfunction

  function automatic void store_row(tlli_pkg::req_t w);
    table_rows[w.entry_index].temperature = w.temperature;
    table_rows[w.entry_index].pressure = w.pressure;
    table_rows[w.entry_index].volume = w.volume;
    table_rows[w.entry_index].energy = w.internal_energy;
    table_rows[w.entry_index].enthalpy = w.enthalpy;
    table_rows[w.entry_index].entropy = w.entropy;
  endfunction

  function automatic tlli_pkg::rsp_t lookup_property(tlli_pkg::req_t w);
    tlli_pkg::rsp_t r;
    longint t, p, x1, x2, y1, y2, dx, dy, v;
    u64_t mag, quot;
    int n;
    bit hit;
    t = wide(w.temperature);
    p = wide(w.pressure);
    n = (entry_count_model > ROWS) ? ROWS : entry_count_model;
    r.value = '0;
    r.status = tlli_pkg::STATUS_NONE;
    hit = 1'b0;
    for (int i = 0; i < n && !hit; i++) begin
      if (magnitude(wide(table_rows[i].temperature) - t) <= tlli_pkg::MATCH_TOL &&
          magnitude(wide(table_rows[i].pressure) - p) <= tlli_pkg::MATCH_TOL) begin
        v = row_prop(i, w.property_select);
        r.value = v[31:0];
        r.status = tlli_pkg::STATUS_EXACT;
        hit = 1'b1;
      end
    end
    for (int i = 0; i + 1 < n && !hit; i++) begin
      x1 = wide(table_rows[i].temperature);
      x2 = wide(table_rows[i + 1].temperature);
      if (x1 <= t && t <= x2) begin
        y1 = row_prop(i, w.property_select);
        y2 = row_prop(i + 1, w.property_select);
        if (x1 == x2) begin
          v = y1;
        end else begin
          dx = t - x1;
          dy = y2 - y1;
          mag = u64_t'(dx) * u64_t'(magnitude(dy));
          quot = mag / u64_t'(x2 - x1);
          v = (dy < 0) ? y1 - longint'(quot) : y1 + longint'(quot);
          if (v > I32_MAX) v = I32_MAX;
          else if (v < I32_MIN) v = I32_MIN;
        end
        r.value = v[31:0];
        r.status = tlli_pkg::STATUS_INTERP;
        hit = 1'b1;
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("mismatch at %0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  // Driver: predict at acceptance, then offer the next word or idle.
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) begin
        if (req.command == tlli_pkg::CMD_QUERY) expected_results.push_back(lookup_property(req));
        else store_row(req);
      end
      if (!start || !busy) begin
        if (word_queue.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          req <= word_queue.pop_front();
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result with none pending: value %0d status %0d",
                                  rsp.value, rsp.status));
      end else begin
        want = expected_results.pop_front();
        if (rsp.value !== want.value)
          report_mismatch($sformatf("value: got %0d want %0d", rsp.value, want.value));
        if (rsp.status !== want.status)
          report_mismatch($sformatf("status: got %0d want %0d", rsp.status, want.status));
      end
    end
  end

  function automatic int q16(int whole);
    return whole <<< 16;
  endfunction

  function automatic int rand_prop();
    return ($urandom_range(1) != 0) ? int'($urandom)
                                    : int'($urandom_range(2_000_000)) - 1_000_000;
  endfunction

  function automatic void push_load(int idx, int t, int p, int v, int e, int h, int s);
    tlli_pkg::req_t w;
    w.command = tlli_pkg::CMD_LOAD;
    w.entry_index = tlli_pkg::INDEX_W'(idx);
    w.temperature = t;
    w.pressure = p;
    w.volume = v;
    w.internal_energy = e;
    w.enthalpy = h;
    w.entropy = s;
    w.property_select = 2'($urandom_range(3));
    word_queue.push_back(w);
    words_queued++;
    gen_temp[idx] = t;
    gen_pres[idx] = p;
  endfunction

  function automatic void push_query(int t, int p, logic [1:0] sel);
    tlli_pkg::req_t w;
    w.command = tlli_pkg::CMD_QUERY;
    w.entry_index = tlli_pkg::INDEX_W'($urandom_range(ROWS - 1));
    w.temperature = t;
    w.pressure = p;
    w.volume = $urandom;
    w.internal_energy = $urandom;
    w.enthalpy = $urandom;
    w.entropy = $urandom;
    w.property_select = sel;
    word_queue.push_back(w);
    words_queued++;
  endfunction

  task automatic drain();
    do @(negedge clk); while (word_queue.size() != 0 || start || expected_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_entry_count(int c);
    @(posedge clk);
    cfg_wr <= 1'b1;
    cfg_data <= tlli_pkg::COUNT_W'(c);
    @(posedge clk);
    cfg_wr <= 1'b0;
    entry_count_model = c;
  endtask

  task automatic random_phase(int count);
    int n, shape, nq, r, k, step_max, t, p, base_p;
    longint acc, lo, hi, span;
    logic [1:0] sel;
    n = (count > ROWS) ? ROWS : count;
    shape = $urandom_range(9);
    acc = longint'(int'($urandom)) / 2;
    case ($urandom_range(4))
      0: step_max = 4;
      1: step_max = 700;
      2: step_max = 2000;
      3: step_max = 1 << 16;
      default: step_max = 1 << 22;
    endcase
    base_p = $urandom;
    for (int i = 0; i < n; i++) begin
      if (shape < 7) begin
        t = (acc > I32_MAX) ? I32_MAX : int'(acc);
        p = base_p + int'($urandom_range(1400)) - 700;
        acc += ($urandom_range(19) == 0) ? 0 : $urandom_range(step_max);
      end else begin
        t = $urandom;
        p = $urandom;
      end
      push_load(i, t, p, rand_prop(), rand_prop(), rand_prop(), rand_prop());
    end
    nq = 20 + $urandom_range(10);
    for (int q = 0; q < nq; q++) begin
      k = $urandom_range(9);
      sel = 2'($urandom_range(3));
      if ($urandom_range(19) == 0) begin
        r = $urandom_range(ROWS - 1);
        push_load(r, gen_temp[r] + int'($urandom_range(2000)) - 1000, gen_pres[r],
                  rand_prop(), rand_prop(), rand_prop(), rand_prop());
      end else if (n == 0 || k == 8) begin
        push_query($urandom, $urandom, sel);
      end else if (k < 4 || n == 1) begin
        r = $urandom_range(n - 1);
        push_query(gen_temp[r] + int'($urandom_range(1400)) - 700,
                   gen_pres[r] + int'($urandom_range(1400)) - 700, sel);
      end else if (k < 8) begin
        r = $urandom_range(n - 2);
        lo = gen_temp[r];
        hi = gen_temp[r + 1];
        if (lo > hi) begin
          span = lo;
          lo = hi;
          hi = span;
        end
        span = hi - lo + 1;
        push_query(int'(lo + (longint'($urandom) % span)), $urandom, sel);
      end else begin
        case ($urandom_range(2))
          0: t = I32_MIN;
          1: t = I32_MAX;
          default: t = gen_temp[0] - int'($urandom_range(3000));
        endcase
        push_query(t, $urandom, sel);
      end
    end
  endtask

  initial begin
    int phase_no;
    int count;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    set_entry_count(0);
    push_load(0, q16(300), q16(1), 1000, -5, I32_MAX, I32_MIN);
    push_load(1, q16(200), q16(1), q16(3), -7000, I32_MIN, I32_MAX);
    push_load(2, q16(200), q16(5), q16(-3), 77, 12345, -12345);
    push_load(3, q16(400), q16(1), q16(9), -77, -1, q16(1000));
    push_load(4, I32_MIN, I32_MAX, I32_MIN, I32_MAX, 0, -1);
    push_load(5, I32_MAX, I32_MIN, I32_MAX, I32_MIN, -1, 0);
    push_query(q16(300), q16(1), tlli_pkg::PROP_VOLUME);
    drain();

    set_entry_count(1);
    push_query(q16(300), q16(1), tlli_pkg::PROP_VOLUME);
    push_query(q16(250), q16(1), tlli_pkg::PROP_ENERGY);
    drain();

    set_entry_count(6);
    push_query(q16(200), q16(100), tlli_pkg::PROP_ENERGY);
    push_query(q16(250), 0, tlli_pkg::PROP_ENTHALPY);
    push_query(q16(300) + 655, q16(1) - 655, tlli_pkg::PROP_ENTROPY);
    push_query(q16(300) + 656, q16(1), tlli_pkg::PROP_VOLUME);
    push_query(q16(400), q16(1), tlli_pkg::PROP_ENERGY);
    push_query(q16(500), 0, tlli_pkg::PROP_VOLUME);
    push_query(q16(500), 0, tlli_pkg::PROP_ENTHALPY);
    push_query(I32_MAX, I32_MIN, tlli_pkg::PROP_ENTROPY);
    push_query(I32_MIN + 1000, 0, tlli_pkg::PROP_ENERGY);
    drain();

    phase_no = 0;
    while (words_queued < WORD_TARGET) begin
      if (words_queued < WORD_TARGET / 3) sender_idle_pct = 7;
      else if (words_queued < 2 * WORD_TARGET / 3) sender_idle_pct = 75;
      else sender_idle_pct = 0;
      if (phase_no < 9) begin
        count = COUNT_PLAN[phase_no];
      end else begin
        case ($urandom_range(9))
          7, 8: count = $urandom_range(ROWS, 13);
          9: count = $urandom_range(127, ROWS + 1);
          default: count = $urandom_range(12, 2);
        endcase
      end
      set_entry_count(count);
      random_phase(count);
      drain();
      phase_no++;
    end

    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
